// ===== src/cdt_pkg.sv =====
// ----------------------------------------------------------------------------
// cdt_pkg
// Shared types, codes and constants of the countdown timer with presets.
// ----------------------------------------------------------------------------
package cdt_pkg;

   localparam int NUM_PRESETS = 2;

   // timer modes
   localparam logic [1:0] MODE_CONFIG = 2'd0;
   localparam logic [1:0] MODE_TICK   = 2'd1;
   localparam logic [1:0] MODE_ALERT  = 2'd2;

   // input actions
   localparam logic [3:0] ACT_TICK         = 4'd0;
   localparam logic [3:0] ACT_GO_CLICK     = 4'd1;
   localparam logic [3:0] ACT_GO_HOLD      = 4'd2;
   localparam logic [3:0] ACT_UP_CLICK     = 4'd3;
   localparam logic [3:0] ACT_DOWN_CLICK   = 4'd4;
   localparam logic [3:0] ACT_UP_HOLD      = 4'd5;
   localparam logic [3:0] ACT_DOWN_HOLD    = 4'd6;
   localparam logic [3:0] ACT_PRESET_CLICK = 4'd7;
   localparam logic [3:0] ACT_PRESET_HOLD  = 4'd8;

   // register indexes
   localparam logic [1:0] REG_COUNT_LIMIT   = 2'd0;
   localparam logic [1:0] REG_MS_PER_SECOND = 2'd1;
   localparam logic [1:0] REG_MINUTES_STEP  = 2'd2;
   localparam logic [1:0] REG_SECONDS_STEP  = 2'd3;

   localparam logic [10:0] RST_COUNT_LIMIT   = 11'd1800;
   localparam logic [9:0]  RST_MS_PER_SECOND = 10'd1000;
   localparam logic [4:0]  RST_MINUTES_STEP  = 5'd5;
   localparam logic [5:0]  RST_SECONDS_STEP  = 6'd10;

   // divide by 60 for values below 2048: (x * 2185) >> 17
   localparam logic [11:0] DIV60_MUL   = 12'd2185;
   localparam int          DIV60_SHIFT = 17;

   typedef struct packed {
      logic [3:0] action;
      logic [9:0] elapsed_ms;
      logic       preset_index;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [11:0] remaining_seconds;
      logic               selected_field;
      logic               buzzer_on;
      logic               beep;
      logic [10:0]        preset_zero;
      logic [10:0]        preset_one;
   } rsp_word_type;

   typedef struct packed {
      logic [10:0] count_limit;
      logic [9:0]  ms_per_second;
      logic [4:0]  min_hold_step;
      logic [5:0]  sec_hold_step;
   } cfg_type;

   typedef struct packed {
      logic [1:0]                   mode;
      logic signed [11:0]           count;
      logic [10:0]                  acc;
      logic                         field_sel;
      logic                         buzzer;
      logic [NUM_PRESETS-1:0][10:0] preset;
   } state_type;

endpackage

// ===== src/cdt_csr.sv =====
// ----------------------------------------------------------------------------
// cdt_csr
// Register file behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module cdt_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output cdt_pkg::cfg_type cfg
);

   cdt_pkg::cfg_type cfg_ff;
   cdt_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [1:0]       reg_sel;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            cdt_pkg::REG_COUNT_LIMIT:   cfg_in.count_limit   = csr_pwdata[10:0];
            cdt_pkg::REG_MS_PER_SECOND: cfg_in.ms_per_second = csr_pwdata[9:0];
            cdt_pkg::REG_MINUTES_STEP:  cfg_in.min_hold_step = csr_pwdata[4:0];
            cdt_pkg::REG_SECONDS_STEP:  cfg_in.sec_hold_step = csr_pwdata[5:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         cdt_pkg::REG_COUNT_LIMIT:   csr_prdata = {21'b0, cfg_ff.count_limit};
         cdt_pkg::REG_MS_PER_SECOND: csr_prdata = {22'b0, cfg_ff.ms_per_second};
         cdt_pkg::REG_MINUTES_STEP:  csr_prdata = {27'b0, cfg_ff.min_hold_step};
         cdt_pkg::REG_SECONDS_STEP:  csr_prdata = {26'b0, cfg_ff.sec_hold_step};
         default: csr_prdata = 32'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.count_limit   <= cdt_pkg::RST_COUNT_LIMIT;
         cfg_ff.ms_per_second <= cdt_pkg::RST_MS_PER_SECOND;
         cfg_ff.min_hold_step <= cdt_pkg::RST_MINUTES_STEP;
         cfg_ff.sec_hold_step <= cdt_pkg::RST_SECONDS_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/cdt_step.sv =====
// ----------------------------------------------------------------------------
// cdt_step
// Next-state logic: applies one input word to the timer state.
// ----------------------------------------------------------------------------
module cdt_step (
   input  cdt_pkg::state_type    state,
   input  cdt_pkg::req_word_type word,
   input  cdt_pkg::cfg_type      cfg,
   output cdt_pkg::state_type    state_nxt,
   output logic                  beep
);

   logic               config_mode;
   logic               up;
   logic               big;
   logic               idx_ok;
   logic [10:0]        cnt_u;
   logic [22:0]        prod;
   logic [5:0]         whole;
   logic [10:0]        whole60;
   logic [5:0]         part;
   logic [4:0]         step_m;
   logic [5:0]         step_s;
   logic [10:0]        step60;
   logic [6:0]         part_plus;
   logic signed [13:0] c_s;
   logic signed [13:0] part_s;
   logic signed [13:0] step_s_s;
   logic signed [13:0] step60_s;
   logic signed [13:0] adj_val;
   logic [10:0]        adj_res;
   logic [10:0]        preset_val;
   logic [10:0]        preset_ld;
   logic [11:0]        acc_sum;
   logic signed [12:0] dec_val;
   logic signed [12:0] neg_max;
   logic signed [11:0] alert_cnt;
   logic signed [11:0] tick_cnt;

   assign config_mode = (state.mode == cdt_pkg::MODE_CONFIG);
   assign up  = (word.action == cdt_pkg::ACT_UP_CLICK) || (word.action == cdt_pkg::ACT_UP_HOLD);
   assign big = (word.action == cdt_pkg::ACT_UP_HOLD) || (word.action == cdt_pkg::ACT_DOWN_HOLD);
   assign idx_ok = (32'(word.preset_index) < cdt_pkg::NUM_PRESETS);

   // in configuring mode the count is never negative
   assign cnt_u   = state.count[10:0];
   assign prod    = {12'b0, cnt_u} * {11'b0, cdt_pkg::DIV60_MUL};
   assign whole   = prod[cdt_pkg::DIV60_SHIFT +: 6];
   assign whole60 = {whole, 5'b0} + {whole, 5'b0} - {3'b0, whole, 2'b0}
                    - {3'b0, whole, 2'b0} + {3'b0, whole, 2'b0};
   assign part    = 6'(cnt_u - whole60);

   assign step_m  = big ? cfg.min_hold_step : 5'd1;
   assign step_s  = big ? cfg.sec_hold_step : 6'd1;
   assign step60  = {step_m, 6'b0} - {4'b0, step_m, 2'b0};
   assign part_plus = {1'b0, part} + {1'b0, step_s};

   assign c_s      = signed'({3'b0, cnt_u});
   assign part_s   = signed'({8'b0, part});
   assign step_s_s = signed'({8'b0, step_s});
   assign step60_s = signed'({3'b0, step60});

   always_comb begin
      if (!state.field_sel) begin
         if (!up && ({1'b0, whole} < {2'b0, step_m})) begin
            adj_val = part_s;
         end else if (up) begin
            adj_val = c_s + step60_s;
         end else begin
            adj_val = c_s - step60_s;
         end
      end else begin
         if (up) begin
            // seconds wrap inside their own field
            if (part_plus >= 7'd60) begin
               adj_val = c_s - part_s;
            end else begin
               adj_val = c_s + step_s_s;
            end
         end else if (part == 6'd0) begin
            adj_val = c_s + 14'sd60 - step_s_s;
         end else if (part <= step_s) begin
            adj_val = c_s - part_s;
         end else begin
            adj_val = c_s - step_s_s;
         end
      end
   end

   always_comb begin
      if (adj_val < 14'sd0) begin
         adj_res = 11'd0;
      end else if (adj_val > signed'({3'b0, cfg.count_limit})) begin
         adj_res = cfg.count_limit;
      end else begin
         adj_res = adj_val[10:0];
      end
   end

   assign preset_val = state.preset[word.preset_index];
   assign preset_ld  = (preset_val > cfg.count_limit) ? cfg.count_limit : preset_val;

   // tick decrement and overtime clamp
   assign acc_sum = {1'b0, state.acc} + {2'b0, word.elapsed_ms};
   assign dec_val = 13'(state.count) - 13'sd1;
   assign neg_max = -signed'({2'b0, cfg.count_limit});
   assign tick_cnt = 12'(dec_val);

   always_comb begin
      if (dec_val > 13'sd0) begin
         alert_cnt = 12'sd0;
      end else if (dec_val < neg_max) begin
         alert_cnt = 12'(neg_max);
      end else begin
         alert_cnt = 12'(dec_val);
      end
   end

   always_comb begin
      state_nxt = state;
      beep      = 1'b0;
      case (word.action)
         cdt_pkg::ACT_TICK: begin
            if (!config_mode) begin
               if (acc_sum >= {2'b0, cfg.ms_per_second}) begin
                  state_nxt.acc = 11'd0;
                  if (state.mode == cdt_pkg::MODE_ALERT) begin
                     state_nxt.buzzer = 1'b1;
                     state_nxt.count  = alert_cnt;
                  end else begin
                     state_nxt.count = tick_cnt;
                  end
               end else begin
                  state_nxt.acc = acc_sum[10:0];
               end
               if ((state.mode == cdt_pkg::MODE_TICK) && (state_nxt.count <= 12'sd0)) begin
                  state_nxt.mode = cdt_pkg::MODE_ALERT;
               end
            end
         end
         cdt_pkg::ACT_GO_CLICK, cdt_pkg::ACT_GO_HOLD: begin
            if (!config_mode) begin
               state_nxt.mode      = cdt_pkg::MODE_CONFIG;
               state_nxt.count     = 12'sd0;
               state_nxt.acc       = 11'd0;
               state_nxt.field_sel = 1'b0;
               state_nxt.buzzer    = 1'b0;
            end else if (word.action == cdt_pkg::ACT_GO_CLICK) begin
               state_nxt.field_sel = ~state.field_sel;
            end else if (state.count > 12'sd0) begin
               state_nxt.mode = cdt_pkg::MODE_TICK;
               state_nxt.acc  = 11'd0;
            end else begin
               beep = 1'b1;
            end
         end
         cdt_pkg::ACT_UP_CLICK, cdt_pkg::ACT_DOWN_CLICK,
         cdt_pkg::ACT_UP_HOLD, cdt_pkg::ACT_DOWN_HOLD: begin
            if (config_mode) begin
               state_nxt.count = signed'({1'b0, adj_res});
            end
         end
         cdt_pkg::ACT_PRESET_CLICK: begin
            if (config_mode && idx_ok) begin
               state_nxt.count = signed'({1'b0, preset_ld});
               if (preset_ld != 11'd0) begin
                  state_nxt.mode = cdt_pkg::MODE_TICK;
                  state_nxt.acc  = 11'd0;
               end else begin
                  beep = 1'b1;
               end
            end
         end
         cdt_pkg::ACT_PRESET_HOLD: begin
            if (config_mode && idx_ok && (state.count > 12'sd0)) begin
               state_nxt.preset[word.preset_index] = state.count[10:0];
               beep = 1'b1;
            end
         end
         default: state_nxt = state;
      endcase
   end

endmodule

// ===== src/countdown_timer_with_presets_core.sv =====
// ----------------------------------------------------------------------------
// countdown_timer_with_presets_core
// Countdown timer controller with two preset slots, driven by button and
// millisecond tick words, one result word per input word.
// ----------------------------------------------------------------------------
// One input word is taken per clock cycle, back to back, while the result
// register is not stalled. Each word is first registered in the input
// register, then the timer state and the result register update together
// when the word is processed. The rate is set by the state feedback loop
// through the next-state logic, which is combinational. A stalled result
// register holds its word while one more input word is still taken into the
// input register. The user must write configuration through the APB-style
// port only while no word is in flight; the block does not enforce this.
module countdown_timer_with_presets_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cdt_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cdt_pkg::rsp_word_type rsp_word,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [3:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cdt_pkg::cfg_type      cfg;
   cdt_pkg::state_type    state_ff;
   cdt_pkg::state_type    state_in;
   cdt_pkg::state_type    state_nxt;
   cdt_pkg::req_word_type in_word_ff;
   cdt_pkg::rsp_word_type rsp_word_ff;
   cdt_pkg::rsp_word_type rsp_word_in;
   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  step_beep;
   logic                  advance;
   logic                  fire;

   cdt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cdt_step u_step (
      .state     (state_ff),
      .word      (in_word_ff),
      .cfg       (cfg),
      .state_nxt (state_nxt),
      .beep      (step_beep)
   );

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      in_valid_in = in_valid_ff && !advance;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end
      state_in = fire ? state_nxt : state_ff;
   end

   always_comb begin
      rsp_word_in.mode              = state_nxt.mode;
      rsp_word_in.remaining_seconds = state_nxt.count;
      rsp_word_in.selected_field    = state_nxt.field_sel;
      rsp_word_in.buzzer_on         = state_nxt.buzzer;
      rsp_word_in.beep              = step_beep;
      rsp_word_in.preset_zero       = state_nxt.preset[0];
      rsp_word_in.preset_one        = (cdt_pkg::NUM_PRESETS > 1) ?
                                      state_nxt.preset[(cdt_pkg::NUM_PRESETS > 1) ? 1 : 0] :
                                      11'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_word;
      end
      if (fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // beep only comes from a refused start or a store, both while configuring
   a_beep_config: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.beep |-> rsp_word_ff.mode == cdt_pkg::MODE_CONFIG)
      else $error("beep outside configuring mode");

   a_buzzer_alert: assert property (@(posedge clock) disable iff (reset)
      state_ff.buzzer |-> state_ff.mode == cdt_pkg::MODE_ALERT)
      else $error("buzzer on outside alerting mode");

   a_alert_nonpos: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == cdt_pkg::MODE_ALERT |-> state_ff.count <= 12'sd0)
      else $error("positive count while alerting");

   a_config_acc: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == cdt_pkg::MODE_CONFIG |-> state_ff.acc == 11'd0)
      else $error("ms accumulator not clear while configuring");

   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed word produced no result");

endmodule
